/* hdl/bkv_pkg.sv */
// ----------------------------------------------------------------------------
// Bounded key/value table package
// Sizes, codes and the structures passed along the chain of table cells.
// ----------------------------------------------------------------------------
package bkv_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int KEY_WIDTH  = 32;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int LIM_W      = 7;
    localparam int CMP_W      = (CNT_W > LIM_W) ? CNT_W : LIM_W;

    localparam logic [LIM_W-1:0] MAX_ENTRIES_RESET = 7'd64;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_FIND   = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    localparam logic [1:0] STATUS_DONE   = 2'd0;
    localparam logic [1:0] STATUS_FULL   = 2'd1;
    localparam logic [1:0] STATUS_EXISTS = 2'd2;
    localparam logic [1:0] STATUS_ABSENT = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DELIVER
    } state_t;

    // Search token that walks the chain, one cell per cycle.
    typedef struct packed {
        logic                  valid;
        logic                  hit;
        logic [IDX_W-1:0]      hit_idx;
        logic                  free;
        logic [IDX_W-1:0]      free_idx;
        logic [DATA_WIDTH-1:0] data;
    } token_t;

    // Table update broadcast to every cell.
    typedef struct packed {
        logic                  set_en;
        logic                  clr_en;
        logic                  clr_all;
        logic [IDX_W-1:0]      set_idx;
        logic [IDX_W-1:0]      clr_idx;
        logic [KEY_WIDTH-1:0]  key;
        logic [DATA_WIDTH-1:0] data;
    } update_t;

endpackage

/* hdl/bkv_cell.sv */
// ----------------------------------------------------------------------------
// Bounded key/value table cell
// Holds one slot and forwards the search token with its own match and
// free-slot findings folded in.
// ----------------------------------------------------------------------------
module bkv_cell (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [bkv_pkg::IDX_W-1:0]           cell_index,
    input  logic [bkv_pkg::KEY_WIDTH-1:0]       req_key,
    input  bkv_pkg::token_t                     tok_in,
    output bkv_pkg::token_t                     tok_out,
    input  bkv_pkg::update_t                    update,
    output logic                                slot_valid
);

    logic                              valid_reg;
    logic [bkv_pkg::KEY_WIDTH-1:0]     key_reg;
    logic [bkv_pkg::DATA_WIDTH-1:0]    data_reg;
    bkv_pkg::token_t                   tok_reg;
    bkv_pkg::token_t                   tok_next;
    logic                              match;

    assign match = valid_reg && (key_reg == req_key);

    always_comb begin
        tok_next          = tok_in;
        tok_next.hit      = tok_in.hit | match;
        tok_next.hit_idx  = tok_in.hit ? tok_in.hit_idx : cell_index;
        tok_next.data     = tok_in.hit ? tok_in.data : data_reg;
        tok_next.free     = tok_in.free | !valid_reg;
        tok_next.free_idx = tok_in.free ? tok_in.free_idx : cell_index;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            tok_reg.valid <= 1'b0;
        end else begin
            tok_reg <= tok_next;
            if (update.clr_all) begin
                valid_reg <= 1'b0;
            end else if (update.clr_en && update.clr_idx == cell_index) begin
                valid_reg <= 1'b0;
            end else if (update.set_en && update.set_idx == cell_index) begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (update.set_en && update.set_idx == cell_index) begin
            key_reg  <= update.key;
            data_reg <= update.data;
        end
    end

    assign tok_out    = tok_reg;
    assign slot_valid = valid_reg;

endmodule

/* hdl/bounded_key_value_table.sv */
// ----------------------------------------------------------------------------
// Bounded key/value table
// Associative table of unique keys with add, delete, find and clear commands.
// ----------------------------------------------------------------------------
// A request on the s_ channel carries a command, a key and a data word; each
// request yields exactly one result on the m_ channel with a status code, the
// found data and the entry count after the command. The limit on entries is
// written through cfg_wr_en and cfg_wr_data; the user must write it only while
// the block is idle, as the block itself does not enforce this. The table is
// a chain of DEPTH cells, one slot each. A search token enters the first cell
// in the cycle after a request is accepted and moves one cell a cycle; when it
// leaves the last cell the table is updated and the result is registered in a
// pending register, then handed to the output register. A new request is taken
// only once the previous result has been handed to the output register, so the
// block serves one request at a time. A result waiting in the output register
// does not block the next request; if the receiver still stalls when the next
// result is ready, that result is held back until the output register is free.
// Reset empties the table, sets the count to zero and the limit to 64, and
// drops any pending result.
// ----------------------------------------------------------------------------
module bounded_key_value_table (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [6:0]         cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_command,
    input  logic signed [31:0] s_key,
    input  logic [31:0]        s_data_in,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic [31:0]        m_data_out,
    output logic [6:0]         m_entry_count
);

    localparam int DEPTH = bkv_pkg::DEPTH;
    localparam int DW    = bkv_pkg::DATA_WIDTH;
    localparam int CNT_W = bkv_pkg::CNT_W;
    localparam int CMP_W = bkv_pkg::CMP_W;

    bkv_pkg::state_t                 state_reg, state_next;
    logic [bkv_pkg::LIM_W-1:0]       max_entries_reg;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic                            start_reg;
    logic [1:0]                      cmd_reg;
    logic [bkv_pkg::KEY_WIDTH-1:0]   key_reg;
    logic [DW-1:0]                   din_reg;
    logic [1:0]                      pend_status_reg, pend_status_next;
    logic [DW-1:0]                   pend_data_reg, pend_data_next;
    logic                            m_valid_reg;
    logic [1:0]                      m_status_reg;
    logic [31:0]                     m_data_reg;
    logic [6:0]                      m_count_reg;

    bkv_pkg::token_t                 chain [0:DEPTH];
    bkv_pkg::token_t                 tail;
    bkv_pkg::update_t                update;
    logic [DEPTH-1:0]                valid_vec;
    logic                            accept;
    logic                            load_out;
    logic [63:0]                     din_wide;
    logic [63:0]                     dout_wide;
    logic [CMP_W-1:0]                limit_ext;
    logic [CMP_W-1:0]                depth_ext;
    logic [CMP_W-1:0]                eff_limit;
    logic                            at_limit;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == bkv_pkg::ST_IDLE);
    assign din_wide = {32'd0, s_data_in};

    always_comb begin
        chain[0]          = '0;
        chain[0].valid    = start_reg;
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        bkv_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cell_index (bkv_pkg::IDX_W'(i)),
            .req_key    (key_reg),
            .tok_in     (chain[i]),
            .tok_out    (chain[i+1]),
            .update     (update),
            .slot_valid (valid_vec[i])
        );
    end

    assign tail      = chain[DEPTH];
    assign limit_ext = CMP_W'(max_entries_reg);
    assign depth_ext = CMP_W'(DEPTH);
    assign eff_limit = (limit_ext < depth_ext) ? limit_ext : depth_ext;
    assign at_limit  = CMP_W'(count_reg) >= eff_limit;
    assign load_out  = (state_reg == bkv_pkg::ST_DELIVER) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        pend_status_next = pend_status_reg;
        pend_data_next   = pend_data_reg;
        update           = '0;
        update.set_idx   = tail.free_idx;
        update.clr_idx   = tail.hit_idx;
        update.key       = key_reg;
        update.data      = din_reg;
        case (state_reg)
            bkv_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = bkv_pkg::ST_SCAN;
                end
            end
            bkv_pkg::ST_SCAN: begin
                if (tail.valid) begin
                    state_next       = bkv_pkg::ST_DELIVER;
                    pend_status_next = bkv_pkg::STATUS_DONE;
                    pend_data_next   = '0;
                    case (cmd_reg)
                        bkv_pkg::CMD_ADD: begin
                            if (at_limit || (!tail.hit && !tail.free)) begin
                                pend_status_next = bkv_pkg::STATUS_FULL;
                            end else if (tail.hit) begin
                                pend_status_next = bkv_pkg::STATUS_EXISTS;
                            end else begin
                                update.set_en = 1'b1;
                                count_next    = count_reg + CNT_W'(1);
                            end
                        end
                        bkv_pkg::CMD_DELETE: begin
                            if (!tail.hit) begin
                                pend_status_next = bkv_pkg::STATUS_ABSENT;
                            end else begin
                                update.clr_en = 1'b1;
                                if (count_reg != '0) begin
                                    count_next = count_reg - CNT_W'(1);
                                end
                            end
                        end
                        bkv_pkg::CMD_FIND: begin
                            if (!tail.hit) begin
                                pend_status_next = bkv_pkg::STATUS_ABSENT;
                            end else begin
                                pend_data_next = tail.data;
                            end
                        end
                        default: begin
                            update.clr_all = 1'b1;
                            count_next     = '0;
                        end
                    endcase
                end
            end
            bkv_pkg::ST_DELIVER: begin
                if (load_out) begin
                    state_next = bkv_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bkv_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= bkv_pkg::ST_IDLE;
            count_reg       <= '0;
            start_reg       <= 1'b0;
            max_entries_reg <= bkv_pkg::MAX_ENTRIES_RESET;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            start_reg <= accept;
            if (cfg_wr_en) begin
                max_entries_reg <= cfg_wr_data;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign dout_wide = 64'(pend_data_reg);

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg <= s_command;
            key_reg <= s_key;
            din_reg <= din_wide[DW-1:0];
        end
        pend_status_reg <= pend_status_next;
        pend_data_reg   <= pend_data_next;
        if (load_out) begin
            m_status_reg <= pend_status_reg;
            m_data_reg   <= dout_wide[31:0];
            m_count_reg  <= 7'(count_reg);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_data_out    = m_data_reg;
    assign m_entry_count = m_count_reg;

    a_count_matches_slots: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == count_reg)
        else $error("Entry count differs from the number of occupied slots.");

    a_tail_only_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        tail.valid |-> state_reg == bkv_pkg::ST_SCAN)
        else $error("Search token left the chain outside a scan.");

    a_accept_starts_token: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> start_reg && state_reg == bkv_pkg::ST_SCAN)
        else $error("Accepted request did not launch a search.");

    a_single_update: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({update.set_en, update.clr_en, update.clr_all}))
        else $error("More than one kind of table update in one cycle.");

endmodule

/* dv/key_table_checker.sv */
// ----------------------------------------------------------------------------
// Key/value table result checker
// Watches both channels of the table, keeps its own copy of the slots, the
// entry count and the entry limit, works out the result of every accepted
// request and compares each delivered result with the oldest one outstanding.
// ----------------------------------------------------------------------------
module key_table_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [31:0] s_key,
    input  logic [31:0] s_data_in,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_status,
    input  logic [31:0] m_data_out,
    input  logic [6:0]  m_entry_count,
    output int          failures,
    output int          pending
);

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] data;
        logic [6:0]  count;
    } outcome_t;

    logic                           slot_used [bkv_pkg::DEPTH];
    logic [bkv_pkg::KEY_WIDTH-1:0]  slot_key  [bkv_pkg::DEPTH];
    logic [bkv_pkg::DATA_WIDTH-1:0] slot_data [bkv_pkg::DEPTH];
    int                             held_entries;
    int                             entry_limit;
    outcome_t                       predicted_outcomes [$];
    outcome_t                       oldest;
    int                             errors = 0;
    int                             results_seen = 0;

    assign failures = errors;

    function automatic outcome_t run_table_command(input logic [1:0] cmd,
                                                   input logic [31:0] key,
                                                   input logic [31:0] data);
        outcome_t r;
        int       hit;
        int       free_slot;
        int       cap;
        r = '0;
        hit = -1;
        free_slot = -1;
        for (int i = 0; i < bkv_pkg::DEPTH; i++) begin
            if (slot_used[i] && slot_key[i] == key && hit < 0) begin
                hit = i;
            end
            if (!slot_used[i] && free_slot < 0) begin
                free_slot = i;
            end
        end
        cap = (entry_limit > bkv_pkg::DEPTH) ? bkv_pkg::DEPTH : entry_limit;
        r.status = bkv_pkg::STATUS_DONE;
        case (cmd)
            bkv_pkg::CMD_ADD: begin
                if (held_entries >= cap || free_slot < 0) begin
                    r.status = bkv_pkg::STATUS_FULL;
                end else if (hit >= 0) begin
                    r.status = bkv_pkg::STATUS_EXISTS;
                end else begin
                    slot_used[free_slot] = 1'b1;
                    slot_key[free_slot]  = key;
                    slot_data[free_slot] = data[bkv_pkg::DATA_WIDTH-1:0];
                    held_entries++;
                end
            end
            bkv_pkg::CMD_DELETE: begin
                if (hit < 0) begin
                    r.status = bkv_pkg::STATUS_ABSENT;
                end else begin
                    slot_used[hit] = 1'b0;
                    held_entries--;
                end
            end
            bkv_pkg::CMD_FIND: begin
                if (hit < 0) begin
                    r.status = bkv_pkg::STATUS_ABSENT;
                end else begin
                    r.data = 32'(slot_data[hit]);
                end
            end
            default: begin
                for (int i = 0; i < bkv_pkg::DEPTH; i++) begin
                    slot_used[i] = 1'b0;
                end
                held_entries = 0;
            end
        endcase
        r.count = 7'(held_entries);
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < bkv_pkg::DEPTH; i++) begin
                slot_used[i] = 1'b0;
            end
            held_entries = 0;
            entry_limit = int'(bkv_pkg::MAX_ENTRIES_RESET);
            predicted_outcomes.delete();
        end else begin
            if (cfg_wr_en) begin
                entry_limit = int'(cfg_wr_data);
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (predicted_outcomes.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("result %0d arrived with no request outstanding",
                                 results_seen);
                    end
                end else begin
                    oldest = predicted_outcomes.pop_front();
                    if (m_status !== oldest.status || m_data_out !== oldest.data ||
                        m_entry_count !== oldest.count) begin
                        errors++;
                        if (errors <= 10) begin
                            $display({"result %0d mismatch (expected/actual): ",
                                      "status %0d/%0d, data %h/%h, count %0d/%0d"},
                                     results_seen, oldest.status, m_status, oldest.data,
                                     m_data_out, oldest.count, m_entry_count);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                predicted_outcomes.push_back(run_table_command(s_command, s_key, s_data_in));
            end
        end
        pending <= predicted_outcomes.size();
    end

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// Key/value table testbench
// Drives a directed run over the key extremes, every command, the full and
// duplicate ordering and the limit corner values, then phases of random
// requests under several entry limits, with bursty requests and a stalling
// receiver. Results are checked by the checker module.
// ----------------------------------------------------------------------------
module testbench;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int RANDOM_REQUESTS = 600;

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               cfg_wr_en     = 1'b0;
    logic [6:0]         cfg_wr_data   = bkv_pkg::MAX_ENTRIES_RESET;
    logic               s_valid       = 1'b0;
    logic               s_ready;
    logic [1:0]         s_command     = bkv_pkg::CMD_FIND;
    logic signed [31:0] s_key         = '0;
    logic [31:0]        s_data_in     = '0;
    logic               m_valid;
    logic               m_ready       = 1'b0;
    logic [1:0]         m_status;
    logic [31:0]        m_data_out;
    logic [6:0]         m_entry_count;

    int                 failures;
    int                 pending;
    int                 quiet_cycles  = 0;
    int                 burst_left    = 0;
    int                 rx_mode       = 0;
    int                 rx_left       = 0;
    logic [31:0]        key_pool [16];

    bounded_key_value_table dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_key         (s_key),
        .s_data_in     (s_data_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_data_out    (m_data_out),
        .m_entry_count (m_entry_count)
    );

    key_table_checker u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_key         (s_key),
        .s_data_in     (s_data_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_data_out    (m_data_out),
        .m_entry_count (m_entry_count),
        .failures      (failures),
        .pending       (pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 2);
            rx_left <= $urandom_range(20, 300);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 1) == 1);
            default: m_ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic issue_request(input logic [1:0] cmd, input logic [31:0] key,
                                 input logic [31:0] data);
        int gap;
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_key     <= key;
        s_data_in <= data;
        do @(posedge aclk); while (!s_ready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 7);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic drain_requests;
        if (s_valid) begin
            s_valid <= 1'b0;
        end
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic program_limit(input logic [6:0] value);
        drain_requests();
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic issue_random(input bit fill);
        int          roll;
        logic [1:0]  cmd;
        logic [31:0] key;
        roll = $urandom_range(0, 99);
        if (roll < (fill ? 80 : 40)) begin
            cmd = bkv_pkg::CMD_ADD;
        end else if (roll < (fill ? 88 : 65)) begin
            cmd = bkv_pkg::CMD_DELETE;
        end else if (fill || roll < 95) begin
            cmd = bkv_pkg::CMD_FIND;
        end else begin
            cmd = bkv_pkg::CMD_CLEAR;
        end
        if ($urandom_range(0, 99) < (fill ? 40 : 85)) begin
            key = key_pool[$urandom_range(0, 15)];
        end else begin
            key = $urandom;
        end
        issue_request(cmd, key, $urandom);
    endtask

    initial begin
        int         phase;
        int         sent;
        int         reqs;
        logic [6:0] lim;
        bit         fill;
        phase = 0;
        sent = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset limit: key extremes, every command and reuse of the lowest free slot.
        issue_request(bkv_pkg::CMD_FIND,   32'h0000_0000, 32'hDEAD_BEEF);
        issue_request(bkv_pkg::CMD_DELETE, 32'h8000_0000, 32'h0000_0000);
        issue_request(bkv_pkg::CMD_ADD,    32'h8000_0000, 32'hFFFF_FFFF);
        issue_request(bkv_pkg::CMD_ADD,    32'h7FFF_FFFF, 32'h0000_0000);
        issue_request(bkv_pkg::CMD_ADD,    32'h0000_0000, 32'hA5A5_A5A5);
        issue_request(bkv_pkg::CMD_ADD,    32'h8000_0000, 32'h1234_5678);
        issue_request(bkv_pkg::CMD_FIND,   32'h8000_0000, 32'h0000_0000);
        issue_request(bkv_pkg::CMD_FIND,   32'h7FFF_FFFF, 32'hFFFF_FFFF);
        issue_request(bkv_pkg::CMD_DELETE, 32'h7FFF_FFFF, 32'h0000_0000);
        issue_request(bkv_pkg::CMD_FIND,   32'h7FFF_FFFF, 32'h0000_0000);
        issue_request(bkv_pkg::CMD_ADD,    32'hFFFF_FFFF, 32'h5A5A_5A5A);
        issue_request(bkv_pkg::CMD_FIND,   32'hFFFF_FFFF, 32'h0000_0000);
        issue_request(bkv_pkg::CMD_CLEAR,  32'h0000_0001, 32'hFFFF_FFFF);
        issue_request(bkv_pkg::CMD_FIND,   32'h0000_0000, 32'h0000_0000);

        // A full table reports full even for a key that is already present.
        program_limit(7'd2);
        issue_request(bkv_pkg::CMD_ADD,    32'h0000_0001, 32'h0000_0011);
        issue_request(bkv_pkg::CMD_ADD,    32'h0000_0002, 32'h0000_0022);
        issue_request(bkv_pkg::CMD_ADD,    32'h0000_0003, 32'h0000_0033);
        issue_request(bkv_pkg::CMD_ADD,    32'h0000_0001, 32'h0000_0044);
        issue_request(bkv_pkg::CMD_DELETE, 32'h0000_0001, 32'h0000_0000);
        issue_request(bkv_pkg::CMD_ADD,    32'h0000_0003, 32'h0000_0033);

        program_limit(7'd0);
        issue_request(bkv_pkg::CMD_ADD,    32'h0000_0005, 32'h0000_0055);
        issue_request(bkv_pkg::CMD_CLEAR,  32'h0000_0000, 32'h0000_0000);

        program_limit(7'd127);
        issue_request(bkv_pkg::CMD_ADD,    32'h0000_0009, 32'h8000_0001);
        issue_request(bkv_pkg::CMD_FIND,   32'h0000_0009, 32'h0000_0000);

        while (sent < RANDOM_REQUESTS) begin
            case (phase % 6)
                0: lim = 7'd64;
                1: lim = 7'd127;
                2: lim = 7'd0;
                3: lim = 7'd1;
                4: lim = 7'($urandom_range(0, 127));
                default: lim = 7'($urandom_range(2, 12));
            endcase
            program_limit(lim);
            fill = (lim > 7'd32);
            foreach (key_pool[i]) begin
                key_pool[i] = $urandom;
            end
            key_pool[0] = 32'h8000_0000;
            key_pool[1] = 32'h7FFF_FFFF;
            key_pool[2] = 32'h0000_0000;
            key_pool[3] = 32'hFFFF_FFFF;
            reqs = fill ? 130 : 50;
            if (reqs > RANDOM_REQUESTS - sent) begin
                reqs = RANDOM_REQUESTS - sent;
            end
            repeat (reqs) begin
                issue_random(fill);
                sent++;
            end
            phase++;
        end

        drain_requests();
        repeat (bkv_pkg::DEPTH + 8) @(posedge aclk);
        if (failures == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
